// ===== src/assert_macros.svh =====
// shared assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/aro_pkg.sv =====
`default_nettype none

package aro_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int IN_DATA_W  = 16;
    localparam int SUM_W      = 16;
    localparam int CFG_W      = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int RANGE_W    = 3;
    localparam int VERDICT_W  = 2;
    localparam int NUM_W      = 37;
    localparam int DIV_W      = 46;
    localparam int DEN_W      = 12;
    localparam int STEP_W     = 6;
    localparam int MUL_A_W    = 28;
    localparam int MUL_B_W    = 24;
    localparam int PROD_W     = 52;
    localparam int MILLI_W    = 47;
    localparam int OUT_DATA_W = 72;

    // block average as a reciprocal multiply, exact for a 16-bit sum and up to 16 samples
    localparam int AVG_SHIFT = 20;

    // divider step count for the milliohm quotient
    localparam logic [STEP_W-1:0] MILLI_STEPS = STEP_W'(DIV_W);

    localparam logic [NUM_W-1:0]   OPEN_OHMS  = 37'd99999999999;
    localparam logic [MILLI_W-1:0] OPEN_MILLI = 47'd99999999999000;

    localparam logic [MUL_B_W-1:0] THRESH_1 = 24'd500;
    localparam logic [MUL_B_W-1:0] THRESH_2 = 24'd9000;
    localparam logic [MUL_B_W-1:0] THRESH_3 = 24'd110000;

    localparam logic [RANGE_W-1:0] RANGE_1 = 3'd1;
    localparam logic [RANGE_W-1:0] RANGE_2 = 3'd2;
    localparam logic [RANGE_W-1:0] RANGE_3 = 3'd3;
    localparam logic [RANGE_W-1:0] RANGE_4 = 3'd4;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_LOW  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_PASS = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_HIGH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED = 2'd3;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    function automatic logic [RANGE_W-1:0] clamp_range(input logic [RANGE_W-1:0] r);
        logic [RANGE_W-1:0] res;
        if (r < RANGE_1)
            res = RANGE_1;
        else if (r > RANGE_4)
            res = RANGE_4;
        else
            res = r;
        return res;
    endfunction

    function automatic logic [MUL_B_W-1:0] range_k(input logic [RANGE_W-1:0] r);
        logic [MUL_B_W-1:0] k;
        case (r)
            RANGE_1: k = 24'd99;
            RANGE_2: k = 24'd985;
            RANGE_3: k = 24'd10000;
            default: k = 24'd11020000;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== src/aro_div.sv =====
`default_nettype none

// restoring serial divider, one quotient bit per cycle
module aro_div
    import aro_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    logic [DIV_W-1:0]  q_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    logic [DEN_W:0] partial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign partial = {rem_reg, q_reg[DIV_W-1]};
    assign ge      = partial >= {1'b0, den_reg};
    assign diff    = partial - {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== src/aro_accum.sv =====
`default_nettype none

// block accumulator: sums samples, flags the last one of each block
module aro_accum
    import aro_pkg::*;
#(
    parameter int AVG_COUNT = 10
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic                     fire,
    output logic [SUM_W-1:0]         total
);

    localparam int CNT_W = (AVG_COUNT > 2) ? $clog2(AVG_COUNT) : 1;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign total = sum_reg + SUM_W'(sample);
    assign fire  = take && (cnt_reg == CNT_W'(AVG_COUNT - 1));

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (fire)
        begin
            sum_next = '0;
            cnt_next = '0;
        end
        else if (take)
        begin
            sum_next = total;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/auto_ranging_ohmmeter.sv =====
// auto-ranging ohmmeter, divider-ratio method
// s_tdata carries converter samples; each block of AVG_COUNT samples gives one
// result on m_tdata/m_tuser. cfg_we/cfg_index/cfg_data write goal, tolerance,
// auto mode and fixed range; write them only while no block is in progress.
// s_tready is high while samples are being collected: one sample per cycle.
// after the last sample of a block, s_tready drops while the block is worked
// out: the block average is taken as a reciprocal multiply, the shared
// multiplier forms the numerator, grade bounds and range thresholds, the
// 46-step serial milliohm divide starts at the third multiplier step, and the
// output register is loaded at the end. an open circuit skips the divide.
// a finished result sits in the output register until taken while the next
// block is collected; a block that finishes while the previous result is
// still stalled waits, with s_tready low, until the output register is free.
// reset clears the partial block, sets range 1, auto mode on, grading off.
`default_nettype none

module auto_ranging_ohmmeter
    import aro_pkg::*;
#(
    parameter int AVG_COUNT = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [11:0] adc_sample
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [46:0] resistance_milliohms, [49:47] range_used, [52:50] next_range,
    // [54:53] verdict, [66:55] average_code
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // [0] open_circuit
    output logic                       m_tuser
);

    typedef enum logic [4:0] {
        S_COLLECT = 5'b00001,
        S_AVG     = 5'b00010,
        S_MUL     = 5'b00100,
        S_DIV     = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    localparam logic [2:0] STEP_NUM  = 3'd0;
    localparam logic [2:0] STEP_LO   = 3'd1;
    localparam logic [2:0] STEP_HI   = 3'd2;
    localparam logic [2:0] STEP_T1   = 3'd3;
    localparam logic [2:0] STEP_T2   = 3'd4;
    localparam logic [2:0] STEP_T3   = 3'd5;
    localparam logic [2:0] STEP_LAST = 3'd6;

    localparam logic [MUL_B_W-1:0] AVG_RECIP =
        MUL_B_W'(((1 << AVG_SHIFT) + AVG_COUNT - 1) / AVG_COUNT);

    state_t state_reg;
    state_t state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;

    logic [CFG_W-1:0]   goal_reg;
    logic [CFG_W-1:0]   tol_reg;
    logic               auto_reg;
    logic [RANGE_W-1:0] fixed_reg;
    logic [RANGE_W-1:0] cur_reg;
    logic [RANGE_W-1:0] cur_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;

    logic [SAMPLE_W-1:0]  a_reg;
    logic                 open_reg;
    logic [RANGE_W-1:0]   rng_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 le_lo_reg;
    logic                 ge_hi_reg;
    logic                 lt1_reg;
    logic                 lt2_reg;
    logic [RANGE_W-1:0]   nxt_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    logic                 acc_fire;
    logic [SUM_W-1:0]     acc_total;
    div_req_t             div_req;
    logic [DIV_W-1:0]     div_dividend;
    logic [DEN_W-1:0]     div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_q;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [DEN_W-1:0]     den;
    logic [MUL_A_W-1:0]   bound_lo;
    logic [MUL_A_W-1:0]   bound_hi;
    logic                 goal_gt_tol;
    logic                 grade_en;
    logic [PROD_W-1:0]    num_wide;
    logic                 lt3;
    logic [RANGE_W-1:0]   nxt_calc;
    logic [VERDICT_W-1:0] verdict_calc;
    logic [DIV_W-1:0]     num_milli;
    logic                 out_free;
    logic [MILLI_W-1:0]   milli;
    logic [SAMPLE_W-1:0]  avg_code;

    assign s_tready = (state_reg == S_COLLECT);
    assign out_free = !m_tvalid_reg || m_tready;

    aro_accum #(
        .AVG_COUNT (AVG_COUNT)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (s_tvalid && s_tready),
        .sample (s_tdata[SAMPLE_W-1:0]),
        .fire   (acc_fire),
        .total  (acc_total)
    );

    aro_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // shared multiplier operands
    assign den         = open_reg ? DEN_W'(1) : a_reg;
    assign goal_gt_tol = goal_reg > tol_reg;
    assign bound_lo    = {1'b0, goal_reg} - {1'b0, tol_reg};
    assign bound_hi    = {1'b0, goal_reg} + {1'b0, tol_reg};
    assign grade_en    = (goal_reg != '0) && (tol_reg != '0);
    assign num_wide    = PROD_W'(num_reg);
    assign num_milli   = DIV_W'(num_reg) * DIV_W'(1000);
    assign avg_code    = prod_reg[AVG_SHIFT +: SAMPLE_W];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_COLLECT)
        begin
            // block sum times the scaled reciprocal of AVG_COUNT
            mul_a = MUL_A_W'(acc_total);
            mul_b = AVG_RECIP;
        end
        else
        begin
            case (step_reg)
                STEP_NUM:
                begin
                    mul_a = MUL_A_W'(13'd4096 - {1'b0, a_reg});
                    mul_b = range_k(rng_reg);
                end
                STEP_LO:
                begin
                    mul_a = bound_lo;
                    mul_b = MUL_B_W'(den);
                end
                STEP_HI:
                begin
                    mul_a = bound_hi;
                    mul_b = MUL_B_W'(den);
                end
                STEP_T1:
                begin
                    mul_a = MUL_A_W'(den);
                    mul_b = THRESH_1;
                end
                STEP_T2:
                begin
                    mul_a = MUL_A_W'(den);
                    mul_b = THRESH_2;
                end
                STEP_T3:
                begin
                    mul_a = MUL_A_W'(den);
                    mul_b = THRESH_3;
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // prod_reg holds the product of the previous step
    assign lt3 = num_wide < prod_reg;

    always_comb
    begin
        if (!auto_reg)
            nxt_calc = rng_reg;
        else if (lt1_reg)
            nxt_calc = RANGE_1;
        else if (lt2_reg)
            nxt_calc = RANGE_2;
        else if (lt3)
            nxt_calc = RANGE_3;
        else
            nxt_calc = RANGE_4;

        if (!grade_en)
            verdict_calc = VERDICT_NONE;
        else if (le_lo_reg)
            verdict_calc = VERDICT_LOW;
        else if (ge_hi_reg)
            verdict_calc = VERDICT_HIGH;
        else
            verdict_calc = VERDICT_PASS;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        div_req       = '{start: 1'b0, steps: MILLI_STEPS};
        div_dividend  = num_milli;
        div_divisor   = a_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (acc_fire)
                    state_next = S_AVG;
            end
            S_AVG:
            begin
                state_next = S_MUL;
                step_next  = STEP_NUM;
            end
            S_MUL:
            begin
                step_next = step_reg + 1'b1;
                // num_reg is ready here, milliohm divide overlaps the compares
                if (step_reg == STEP_HI && !open_reg)
                    div_req.start = 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    cur_next   = nxt_calc;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (open_reg || div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_COLLECT;
            step_reg     <= STEP_NUM;
            cur_reg      <= RANGE_1;
            m_tvalid_reg <= 1'b0;
            goal_reg     <= '0;
            tol_reg      <= '0;
            auto_reg     <= 1'b1;
            fixed_reg    <= RANGE_1;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GOAL:  goal_reg  <= cfg_data;
                    CFG_TOL:   tol_reg   <= cfg_data;
                    CFG_AUTO:  auto_reg  <= cfg_data[0];
                    CFG_FIXED: fixed_reg <= cfg_data[RANGE_W-1:0];
                    default:   goal_reg  <= goal_reg;
                endcase
            end
        end
    end

    assign milli = open_reg ? OPEN_MILLI : MILLI_W'(div_q);

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);

        if (state_reg == S_AVG)
        begin
            a_reg    <= avg_code;
            open_reg <= (avg_code == '0);
            rng_reg  <= auto_reg ? cur_reg : clamp_range(fixed_reg);
        end

        if (state_reg == S_MUL)
        begin
            case (step_reg)
                STEP_LO:   num_reg   <= open_reg ? OPEN_OHMS : prod_reg[NUM_W-1:0];
                STEP_HI:   le_lo_reg <= goal_gt_tol && (num_wide <= prod_reg);
                STEP_T1:   ge_hi_reg <= num_wide >= prod_reg;
                STEP_T2:   lt1_reg   <= num_wide < prod_reg;
                STEP_T3:   lt2_reg   <= num_wide < prod_reg;
                STEP_LAST:
                begin
                    nxt_reg     <= nxt_calc;
                    verdict_reg <= verdict_calc;
                end
                default:   num_reg   <= num_reg;
            endcase
        end

        if (state_reg == S_DONE && out_free)
        begin
            m_tdata_reg <= {5'b0, a_reg, verdict_reg, nxt_reg, rng_reg, milli};
            m_tuser_reg <= open_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== src/aro_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module aro_checker
    import aro_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tuser
);

    logic ranges_ok;

    assign ranges_ok = (m_tdata[49:47] >= RANGE_1) && (m_tdata[49:47] <= RANGE_4)
                    && (m_tdata[52:50] >= RANGE_1) && (m_tdata[52:50] <= RANGE_4);

    // a pending result is not withdrawn
    `ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

    // a pending result keeps its contents
    `ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // open circuit exactly when the average is zero, with the fixed value
    `ASSERT_IMP(a_open_code, m_tvalid, m_tuser == (m_tdata[66:55] == '0))
    `ASSERT_IMP(a_open_value, m_tvalid && m_tuser, m_tdata[46:0] == OPEN_MILLI)

    // both ranges in 1..4
    `ASSERT_IMP(a_range_ok, m_tvalid, ranges_ok)

endmodule

bind auto_ranging_ohmmeter aro_checker u_aro_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== bench/tb_auto_ranging_ohmmeter.sv =====
`timescale 1ns / 100ps

module tb_auto_ranging_ohmmeter;
    import aro_pkg::*;

    localparam int BLOCK_LEN    = 10;
    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    typedef struct packed {
        logic [MILLI_W-1:0]   milliohms;
        logic [RANGE_W-1:0]   range_used;
        logic [RANGE_W-1:0]   next_range;
        logic [VERDICT_W-1:0] verdict;
        logic [SAMPLE_W-1:0]  avg_code;
        logic                 open_circuit;
    } reading_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GOAL;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [11:0] adc_sample
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [46:0] resistance_milliohms, [49:47] range_used, [52:50] next_range,
    // [54:53] verdict, [66:55] average_code
    logic [OUT_DATA_W-1:0] m_tdata;
    // [0] open_circuit
    logic                  m_tuser;

    // meter model state and register copies
    logic [CFG_W-1:0]   goal_ohms_m = '0;
    logic [CFG_W-1:0]   tol_ohms_m = '0;
    logic               auto_m = 1'b1;
    logic [RANGE_W-1:0] fixed_m = RANGE_1;
    logic [SUM_W-1:0]   block_sum = '0;
    int                 block_fill = 0;
    logic [RANGE_W-1:0] active_range = RANGE_1;

    reading_t    pending_readings[$];
    int          errors = 0;
    int unsigned cycle_count = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          hold_request = 0;

    auto_ranging_ohmmeter #(
        .AVG_COUNT(BLOCK_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [RANGE_W-1:0] limit_range(input logic [RANGE_W-1:0] r);
        return (r == '0) ? RANGE_1 : ((r > RANGE_4) ? RANGE_4 : r);
    endfunction

    function automatic longint unsigned divider_k(input logic [RANGE_W-1:0] r);
        case (r)
            RANGE_1: return 64'd99;
            RANGE_2: return 64'd985;
            RANGE_3: return 64'd10000;
            default: return 64'd11020000;
        endcase
    endfunction

    // adds one sample to the running block; a full block yields one reading
    function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] sample);
        reading_t           rd;
        logic [SAMPLE_W-1:0] a;
        logic [RANGE_W-1:0] rng;
        logic [RANGE_W-1:0] nxt;
        longint unsigned    num;
        longint unsigned    den;
        longint             lo;
        longint             hi;
        block_sum = block_sum + SUM_W'(sample);
        block_fill++;
        if (block_fill != BLOCK_LEN)
            return;
        a = SAMPLE_W'(int'(block_sum) / BLOCK_LEN);
        block_sum = '0;
        block_fill = 0;
        rng = auto_m ? limit_range(active_range) : limit_range(fixed_m);
        rd.open_circuit = (a == '0);
        if (rd.open_circuit)
        begin
            num = 64'(OPEN_OHMS);
            den = 64'd1;
            rd.milliohms = OPEN_MILLI;
        end
        else
        begin
            num = (64'd4096 - 64'(a)) * divider_k(rng);
            den = 64'(a);
            rd.milliohms = MILLI_W'((num * 64'd1000) / den);
        end
        // grading compares cross products so no rounding enters
        rd.verdict = VERDICT_NONE;
        if (goal_ohms_m != '0 && tol_ohms_m != '0)
        begin
            lo = (longint'(goal_ohms_m) - longint'(tol_ohms_m)) * longint'(den);
            hi = (longint'(goal_ohms_m) + longint'(tol_ohms_m)) * longint'(den);
            if (longint'(num) <= lo)
                rd.verdict = VERDICT_LOW;
            else if (longint'(num) >= hi)
                rd.verdict = VERDICT_HIGH;
            else
                rd.verdict = VERDICT_PASS;
        end
        if (auto_m)
        begin
            if (num < 64'd500 * den)
                nxt = RANGE_1;
            else if (num < 64'd9000 * den)
                nxt = RANGE_2;
            else if (num < 64'd110000 * den)
                nxt = RANGE_3;
            else
                nxt = RANGE_4;
        end
        else
            nxt = rng;
        active_range = nxt;
        rd.range_used = rng;
        rd.next_range = nxt;
        rd.avg_code = a;
        pending_readings.push_back(rd);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        reading_t exp_rd;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected transaction: m_tdata %0h m_tuser %0b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                exp_rd = pending_readings.pop_front();
                check_field("resistance_milliohms", 64'(exp_rd.milliohms),
                            64'(m_tdata[46:0]));
                check_field("range_used", 64'(exp_rd.range_used), 64'(m_tdata[49:47]));
                check_field("next_range", 64'(exp_rd.next_range), 64'(m_tdata[52:50]));
                check_field("verdict", 64'(exp_rd.verdict), 64'(m_tdata[54:53]));
                check_field("average_code", 64'(exp_rd.avg_code), 64'(m_tdata[66:55]));
                check_field("open_circuit", 64'(exp_rd.open_circuit), 64'(m_tuser));
            end
        end
    end

    // output side: random stalls, steady phases, and one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_steady)
                m_tready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'(sample);
        do
            @(posedge clk);
        while (!s_tready);
        accumulate_sample(sample);
        gap = tx_steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    // spreads a block sum evenly so the truncated average is total / BLOCK_LEN
    task automatic send_block_total(input int total);
        for (int i = 0; i < BLOCK_LEN; i++)
            send_sample(SAMPLE_W'(total / BLOCK_LEN + ((i < total % BLOCK_LEN) ? 1 : 0)));
    endtask

    task automatic send_random_block();
        int kind;
        int base;
        int v;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 4095);
        for (int i = 0; i < BLOCK_LEN; i++)
        begin
            case (kind)
                0: v = $urandom_range(0, 4095);
                1: v = 0;
                2: v = $urandom_range(0, 3);
                3: v = $urandom_range(4080, 4095);
                default:
                begin
                    v = base + int'($urandom_range(0, 16)) - 8;
                    if (v < 0)
                        v = 0;
                    if (v > 4095)
                        v = 4095;
                end
            endcase
            send_sample(SAMPLE_W'(v));
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        // a further drain lets any unexpected extra transaction show up before going on
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GOAL:  goal_ohms_m = val;
            CFG_TOL:   tol_ohms_m = val;
            CFG_AUTO:  auto_m = val[0];
            CFG_FIXED: fixed_m = val[RANGE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] goal, input logic [CFG_W-1:0] tol,
                                 input logic autom, input logic [RANGE_W-1:0] fixed);
        wait_idle();
        write_reg(CFG_GOAL, goal);
        write_reg(CFG_TOL, tol);
        write_reg(CFG_AUTO, CFG_W'(autom));
        write_reg(CFG_FIXED, CFG_W'(fixed));
    endtask

    task automatic grade_case(input logic [CFG_W-1:0] goal, input logic [CFG_W-1:0] tol,
                              input logic [RANGE_W-1:0] fixed, input int total);
        load_settings(goal, tol, 1'b0, fixed);
        send_block_total(total);
    endtask

    function automatic logic [CFG_W-1:0] pick_ohms();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_W'($urandom_range(1, 600));
            2: return CFG_W'($urandom_range(1, 20000));
            3: return CFG_W'($urandom_range(1, 99999999));
            4: return CFG_MAX;
            default: return CFG_W'($urandom_range(100, 2000000));
        endcase
    endfunction

    // reset settings: auto ranging, no grading
    task automatic test_power_on_defaults();
        send_block_total(0);
        send_block_total(40950);
        send_block_total(19);
        send_block_total(20480);
        for (int i = 0; i < BLOCK_LEN; i++)
            send_sample((i % 2) ? 12'h555 : 12'hAAA);
        send_block_total(12345);
    endtask

    task automatic test_fixed_ranges();
        for (int r = 0; r < 8; r++)
        begin
            load_settings('0, '0, 1'b0, RANGE_W'(r));
            send_block_total(20480);
        end
        // auto mode picks up from the clamped fixed range
        load_settings('0, '0, 1'b1, RANGE_1);
        send_block_total(20480);
        send_block_total(40950);
    endtask

    task automatic test_grade_bounds();
        // range 1 at half scale reads exactly 99 ohms
        grade_case(100, 1, RANGE_1, 20480);
        grade_case(99, 1, RANGE_1, 20480);
        grade_case(98, 1, RANGE_1, 20480);
        grade_case(50, 200, RANGE_1, 20480);
        grade_case(0, 7, RANGE_1, 20480);
        grade_case(7, 0, RANGE_1, 20480);
        grade_case(CFG_MAX, CFG_MAX, RANGE_1, 20480);
        // range 2 with average 3 lands between whole ohms
        grade_case(1343869, 1, RANGE_2, 35);
        grade_case(1343867, 1, RANGE_2, 35);
        load_settings(CFG_MAX, 1, 1'b1, RANGE_1);
        send_block_total(0);
        send_block_total(9);
    endtask

    task automatic test_output_backpressure();
        load_settings('0, '0, 1'b1, RANGE_1);
        tx_steady = 1'b1;
        hold_request = 600;
        repeat (6) send_random_block();
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] goal;
        logic [CFG_W-1:0] tol;
        for (int phase = 0; phase < 8; phase++)
        begin
            goal = pick_ohms();
            tol = pick_ohms();
            tx_steady = (phase % 4 == 1);
            rx_steady = (phase % 4 == 2);
            load_settings(goal, tol, $urandom_range(0, 3) != 0, RANGE_W'($urandom_range(0, 7)));
            repeat (12) send_random_block();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_power_on_defaults();
        test_fixed_ranges();
        test_grade_bounds();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        if (errors == 0 && pending_readings.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
